[hdl/tisp_pkg.sv]
package tisp_pkg;

   typedef logic [2:0]  kind_type;
   typedef logic [20:0] size_type;
   typedef logic [7:0]  byte_type;

   localparam kind_type KIND_KEY_BYTE   = 3'd0;
   localparam kind_type KIND_KEY_END    = 3'd1;
   localparam kind_type KIND_VALUE_BYTE = 3'd2;
   localparam kind_type KIND_ITEM_END   = 3'd3;
   localparam kind_type KIND_CORRUPT    = 3'd4;

   localparam size_type MIN_ITEM_BYTES  = 21'd9;
   localparam size_type HEADER_LAST     = 21'd7;
   localparam size_type LONG_KEY_LEN    = 21'd11;
   localparam size_type SHORT_KEY_LEN   = 21'd4;
   localparam logic [2:0] DATE_VALUE_MAX = 3'd4;

   // match bit 0: "record date", bit 1: "year", bit 2: "date"
   function automatic byte_type pat_char(input logic [1:0] pat, input logic [3:0] idx);
      byte_type c;
      c = 8'h00;
      unique case (pat)
         2'd0: begin
            case (idx)
               4'd0:    c = "r";
               4'd1:    c = "e";
               4'd2:    c = "c";
               4'd3:    c = "o";
               4'd4:    c = "r";
               4'd5:    c = "d";
               4'd6:    c = " ";
               4'd7:    c = "d";
               4'd8:    c = "a";
               4'd9:    c = "t";
               4'd10:   c = "e";
               default: c = 8'h00;
            endcase
         end
         2'd1: begin
            case (idx)
               4'd0:    c = "y";
               4'd1:    c = "e";
               4'd2:    c = "a";
               4'd3:    c = "r";
               default: c = 8'h00;
            endcase
         end
         default: begin
            case (idx)
               4'd0:    c = "d";
               4'd1:    c = "a";
               4'd2:    c = "t";
               4'd3:    c = "e";
               default: c = 8'h00;
            endcase
         end
      endcase
      return c;
   endfunction

   function automatic byte_type to_lower(input byte_type b);
      return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
   endfunction

endpackage

[hdl/tisp_if.sv]
interface tisp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       body_start;

   modport source(output valid, output data_byte, output body_start, input ready);
   modport sink(input valid, input data_byte, input body_start, output ready);
endinterface

interface tisp_rsp_if import tisp_pkg::*; ();
   logic     valid;
   logic     ready;
   kind_type kind;
   byte_type out_byte;
   logic     date_key;
   logic     item_last;

   modport source(output valid, output kind, output out_byte, output date_key,
                  output item_last, input ready);
   modport sink(input valid, input kind, input out_byte, input date_key,
                input item_last, output ready);
endinterface

interface tisp_csr_if import tisp_pkg::*; ();
   logic     valid;
   logic     ready;
   size_type body_size;

   modport source(output valid, output body_size, input ready);
   modport sink(input valid, input body_size, output ready);
endinterface

[hdl/tag_item_stream_parser.sv]
// Channel | Dir | Payload                                 | Handshake
// req     | in  | data_byte[7:0], body_start              | valid/ready
// rsp     | out | kind[2:0], out_byte[7:0], date_key, item_last | valid/ready
// csr     | in  | body_size[20:0]                         | valid/ready, always ready
//
// One word per cycle sustained while rsp is ready; a word is on rsp once its byte
// passes the input register, then the result register after the parse logic.
// Reset is synchronous and active high; it clears the parser state and body_size.
// A stalled rsp holds its word; req keeps accepting while the input register
// drains into a free or emptying result register.
module tag_item_stream_parser import tisp_pkg::*; #(
   parameter int unsigned MAX_BODY_BYTES = 1048576
) (
   input  logic         clock,
   input  logic         reset,
   tisp_req_if.sink     req,
   tisp_rsp_if.source   rsp,
   tisp_csr_if.sink     csr
);

   localparam logic [1:0] PH_HDR  = 2'd0;
   localparam logic [1:0] PH_KEY  = 2'd1;
   localparam logic [1:0] PH_VAL  = 2'd2;
   localparam logic [1:0] PH_SKIP = 2'd3;

   size_type   body_size_ff;

   logic       in_valid_ff, in_valid_in;
   byte_type   in_byte_ff;
   logic       in_start_ff;

   logic [1:0] phase_ff, phase_in;
   size_type   bytes_left_ff, bytes_left_in;
   size_type   field_count_ff, field_count_in;
   logic [31:0] value_length_ff, value_length_in;
   logic [1:0] flags_ff, flags_in;
   size_type   key_limit_ff, key_limit_in;
   logic [2:0] match_ff, match_in;
   logic [2:0] emitted_ff, emitted_in;
   logic       nul_ff, nul_in;
   logic       stopped_ff, stopped_in;

   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   rsp_kind_ff, kind_in;
   byte_type   rsp_byte_ff, byte_in;
   logic       rsp_date_ff, date_in;
   logic       rsp_last_ff, last_in;
   logic       fire;

   logic       step;
   logic       text;
   logic       oversize;
   logic [1:0] ph_c;
   size_type   fc_c;
   size_type   bl_c;
   logic       stop_c;
   size_type   bl_dec;
   logic [31:0] vl_dec;
   logic [2:0] m_key;
   logic       nul_n;
   logic       val_last;
   byte_type   low_b;

   assign step      = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || step;
   assign csr.ready = 1'b1;

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.kind      = rsp_kind_ff;
   assign rsp.out_byte  = rsp_byte_ff;
   assign rsp.date_key  = rsp_date_ff;
   assign rsp.item_last = rsp_last_ff;

   assign oversize = {11'd0, body_size_ff} > 32'(MAX_BODY_BYTES);
   assign text     = flags_ff == 2'b00;
   assign low_b    = to_lower(in_byte_ff);

   always_comb begin
      ph_c   = in_start_ff ? PH_HDR : phase_ff;
      fc_c   = in_start_ff ? '0 : field_count_ff;
      stop_c = in_start_ff ? 1'b0 : stopped_ff;
      bl_c   = in_start_ff ? (oversize ? '0 : body_size_ff) : bytes_left_ff;

      phase_in        = ph_c;
      field_count_in  = fc_c;
      stopped_in      = stop_c;
      bytes_left_in   = bl_c;
      value_length_in = value_length_ff;
      flags_in        = flags_ff;
      key_limit_in    = key_limit_ff;
      match_in        = match_ff;
      emitted_in      = emitted_ff;
      nul_in          = nul_ff;

      fire     = 1'b0;
      kind_in  = KIND_KEY_BYTE;
      byte_in  = 8'h00;
      date_in  = 1'b0;
      last_in  = 1'b0;
      bl_dec   = bl_c - 21'd1;
      vl_dec   = value_length_ff - 32'd1;
      m_key    = match_ff & {fc_c == SHORT_KEY_LEN, fc_c == SHORT_KEY_LEN,
                             fc_c == LONG_KEY_LEN};
      nul_n    = nul_ff || (in_byte_ff == 8'h00);
      val_last = vl_dec == 32'd0;

      if (!stop_c && bl_c != '0) begin
         if (ph_c == PH_HDR && fc_c == '0 && bl_c < MIN_ITEM_BYTES) begin
            stopped_in = 1'b1;
         end else begin
            bytes_left_in = bl_dec;
            unique case (ph_c)
               PH_HDR: begin
                  case (fc_c[2:0])
                     3'd0: begin
                        value_length_in = {24'd0, in_byte_ff};
                        flags_in        = 2'b00;
                     end
                     3'd1: value_length_in[15:8]  = in_byte_ff;
                     3'd2: value_length_in[23:16] = in_byte_ff;
                     3'd3: value_length_in[31:24] = in_byte_ff;
                     3'd4: flags_in = in_byte_ff[2:1];
                     default: ;
                  endcase
                  field_count_in = fc_c + 21'd1;
                  if (fc_c == HEADER_LAST) begin
                     if ({1'b0, value_length_in} + 33'd1 > {12'd0, bl_dec}) begin
                        stopped_in = 1'b1;
                        fire       = 1'b1;
                        kind_in    = KIND_CORRUPT;
                        last_in    = 1'b1;
                     end else begin
                        key_limit_in   = bl_dec - value_length_in[20:0] - 21'd1;
                        phase_in       = PH_KEY;
                        field_count_in = '0;
                        match_in       = 3'b111;
                     end
                  end
               end
               PH_KEY: begin
                  if (in_byte_ff == 8'h00) begin
                     match_in   = m_key;
                     emitted_in = 3'd0;
                     nul_in     = 1'b0;
                     if (value_length_ff == 32'd0) begin
                        phase_in       = PH_HDR;
                        field_count_in = '0;
                     end else begin
                        phase_in = text ? PH_VAL : PH_SKIP;
                     end
                     fire    = text;
                     kind_in = KIND_KEY_END;
                     date_in = |m_key;
                     last_in = value_length_ff == 32'd0;
                  end else if (fc_c >= key_limit_ff) begin
                     stopped_in = 1'b1;
                     fire       = 1'b1;
                     kind_in    = KIND_CORRUPT;
                     last_in    = 1'b1;
                  end else begin
                     if (fc_c >= LONG_KEY_LEN || low_b != pat_char(2'd0, fc_c[3:0]))
                        match_in[0] = 1'b0;
                     if (fc_c >= SHORT_KEY_LEN || low_b != pat_char(2'd1, fc_c[3:0]))
                        match_in[1] = 1'b0;
                     if (fc_c >= SHORT_KEY_LEN || low_b != pat_char(2'd2, fc_c[3:0]))
                        match_in[2] = 1'b0;
                     field_count_in = fc_c + 21'd1;
                     fire    = text;
                     kind_in = KIND_KEY_BYTE;
                     byte_in = in_byte_ff;
                  end
               end
               PH_VAL: begin
                  value_length_in = vl_dec;
                  nul_in          = nul_n;
                  if (val_last) begin
                     phase_in       = PH_HDR;
                     field_count_in = '0;
                  end
                  if (!nul_n && (match_ff == 3'b000 || emitted_ff < DATE_VALUE_MAX)) begin
                     if (emitted_ff < DATE_VALUE_MAX)
                        emitted_in = emitted_ff + 3'd1;
                     fire    = 1'b1;
                     kind_in = KIND_VALUE_BYTE;
                     byte_in = in_byte_ff;
                     last_in = val_last;
                  end else if (val_last) begin
                     fire    = 1'b1;
                     kind_in = KIND_ITEM_END;
                     last_in = 1'b1;
                  end
               end
               PH_SKIP: begin
                  value_length_in = vl_dec;
                  if (val_last) begin
                     phase_in       = PH_HDR;
                     field_count_in = '0;
                  end
               end
            endcase
         end
      end
   end

   assign in_valid_in  = req.ready ? req.valid : in_valid_ff;
   assign rsp_valid_in = (step && fire) ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         body_size_ff    <= '0;
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= PH_HDR;
         bytes_left_ff   <= '0;
         field_count_ff  <= '0;
         value_length_ff <= '0;
         flags_ff        <= 2'b00;
         key_limit_ff    <= '0;
         match_ff        <= 3'b111;
         emitted_ff      <= 3'd0;
         nul_ff          <= 1'b0;
         stopped_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid) begin
            body_size_ff <= csr.body_size;
         end
         if (step) begin
            phase_ff        <= phase_in;
            bytes_left_ff   <= bytes_left_in;
            field_count_ff  <= field_count_in;
            value_length_ff <= value_length_in;
            flags_ff        <= flags_in;
            key_limit_ff    <= key_limit_in;
            match_ff        <= match_in;
            emitted_ff      <= emitted_in;
            nul_ff          <= nul_in;
            stopped_ff      <= stopped_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff  <= req.data_byte;
         in_start_ff <= req.body_start;
      end
      if (step && fire) begin
         rsp_kind_ff <= kind_in;
         rsp_byte_ff <= byte_in;
         rsp_date_ff <= date_in;
         rsp_last_ff <= last_in;
      end
   end

endmodule

[hdl/tisp_checker.sv]
module tisp_rsp_assertions import tisp_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input kind_type rsp_kind,
   input byte_type rsp_out_byte,
   input logic     rsp_date_key,
   input logic     rsp_item_last
);

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_KEY_BYTE && rsp_kind != KIND_VALUE_BYTE
      |-> rsp_out_byte == 8'h00)
      else $error("out_byte set on a word without a byte");

   a_date_only_key_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_KEY_END |-> !rsp_date_key)
      else $error("date_key set outside key end");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ITEM_END || rsp_kind == KIND_CORRUPT)
      |-> rsp_item_last && !(rsp_kind == KIND_KEY_BYTE))
      else $error("item end or corrupt word without item_last");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
      && $stable(rsp_out_byte))
      else $error("stalled word changed");

endmodule

bind tag_item_stream_parser tisp_rsp_assertions u_tisp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_kind     (rsp.kind),
   .rsp_out_byte (rsp.out_byte),
   .rsp_date_key (rsp.date_key),
   .rsp_item_last(rsp.item_last)
);
